FILE: rtl/dali_manchester_transceiver_unit_defines.svh
// Assertion macros shared by the checker of the DALI transceiver.
`ifndef DALI_MANCHESTER_TRANSCEIVER_UNIT_DEFINES_SVH
`define DALI_MANCHESTER_TRANSCEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMT_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("transceiver check failed");

// Next-cycle implication, checked outside reset.
`define DMT_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("transceiver check failed");

`endif

FILE: rtl/dmt_pkg.sv
// Shared constants, types and the run classifier of the DALI transceiver.
package dmt_pkg;

	localparam int DEF_MAX_RUNS = 128;
	localparam int DEF_MAX_TX_PULSES = 64;
	localparam int DEF_FRAME_WIDTH = 32;

	localparam int RUN_W = 10;
	localparam logic [RUN_W-1:0] RUN_SAT = 10'h3FF;
	localparam int MIN_RUNS = 5;
	localparam int STOP_HALVES = 3;

	localparam logic [2:0] CFG_RX_INV = 3'd0;
	localparam logic [2:0] CFG_TX_INV = 3'd1;
	localparam logic [2:0] CFG_HALF = 3'd2;
	localparam logic [2:0] CFG_HYST = 3'd3;
	localparam logic [2:0] CFG_SHORT = 3'd4;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SEND_NOW = 2'd1;
	localparam logic [1:0] CMD_SEND_DELAY = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef enum logic [1:0] {CLS_HALF, CLS_FULL, CLS_STOP, CLS_ERR} cls_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] data;
		logic [6:0]  bits;
	} dec_res_t;

	// Classify one run length against the half-bit timing.
	function automatic cls_t classify(input logic [RUN_W-1:0] v, input logic [7:0] h,
		input logic [6:0] hy, input logic [7:0] lim);
		logic signed [11:0] sv, sh, shy;
		sv = $signed({2'b00, v});
		sh = $signed({4'b0000, h});
		shy = $signed({5'b00000, hy});
		if (sv >= sh - shy && sv <= sh + shy) return CLS_HALF;
		if (sv >= sh + sh - shy && sv <= sh + sh + shy) return CLS_FULL;
		if (sv >= sh + sh + sh - shy || v <= {2'b00, lim}) return CLS_STOP;
		return CLS_ERR;
	endfunction

endpackage

FILE: rtl/dmt_decoder.sv
// Run length memory and the sequential frame decoder that walks it.
module dmt_decoder #(
	parameter int MAX_RUNS = dmt_pkg::DEF_MAX_RUNS,
	parameter int FRAME_WIDTH = dmt_pkg::DEF_FRAME_WIDTH,
	localparam int RAW = $clog2(MAX_RUNS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [RAW-1:0]              wr_addr,
	input  logic [dmt_pkg::RUN_W-1:0]   wr_data,
	input  logic                        start,
	input  logic [RAW:0]                run_total,
	input  logic [7:0]                  half_ticks,
	input  logic [6:0]                  hyst_ticks,
	input  logic [7:0]                  short_limit,
	output logic                        done,
	output dmt_pkg::dec_res_t           res
);
	localparam int FAW = $clog2(FRAME_WIDTH);

	typedef enum logic [2:0] {D_IDLE, D_ORD, D_OEV, D_IRD, D_IEV, D_FIN} dstate_t;

	logic [dmt_pkg::RUN_W-1:0] mem [MAX_RUNS];
	logic [dmt_pkg::RUN_W-1:0] rd_data_q;
	logic [RAW-1:0] rd_addr;
	dstate_t st_q;
	logic [RAW:0] i_q, j_q, cnt_q;
	logic zero_q;
	logic [FRAME_WIDTH-1:0] rec_q, recx;
	logic [7:0] nb_q, m;
	dmt_pkg::cls_t cls;

	// The outer walk reads at i, the inner walk at j.
	assign rd_addr = (st_q == D_ORD) ? i_q[RAW-1:0] : j_q[RAW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	assign cls = dmt_pkg::classify(rd_data_q, half_ticks, hyst_ticks, short_limit);

	// The first decoded bit is the start bit; flip it back out.
	always_comb begin
		m = nb_q - 8'd1;
		recx = rec_q;
		if (nb_q != 8'd0 && {24'd0, m} < FRAME_WIDTH) recx[m[FAW-1:0]] = ~recx[m[FAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			done <= 1'b0;
			res <= '0;
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			zero_q <= 1'b0;
			rec_q <= '0;
			nb_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						cnt_q <= run_total;
						i_q <= '0;
						zero_q <= 1'b0;
						rec_q <= '0;
						nb_q <= '0;
						if ({{(31-RAW){1'b0}}, run_total} <= dmt_pkg::MIN_RUNS) begin
							res <= '0;
							done <= 1'b1;
						end else begin
							st_q <= D_ORD;
						end
					end
				end
				D_ORD: st_q <= (i_q >= cnt_q) ? D_FIN : D_OEV;
				D_OEV: begin
					if (cls == dmt_pkg::CLS_STOP) begin
						st_q <= D_FIN;
					end else begin
						j_q <= i_q + 1'b1;
						st_q <= D_IRD;
					end
				end
				D_IRD: begin
					if (j_q >= cnt_q) begin
						i_q <= i_q + 1'b1;
						st_q <= D_ORD;
					end else begin
						st_q <= D_IEV;
					end
				end
				D_IEV: begin
					rec_q <= {rec_q[FRAME_WIDTH-2:0], ~zero_q};
					if (nb_q != 8'hFF) nb_q <= nb_q + 8'd1;
					if (cls == dmt_pkg::CLS_FULL) begin
						zero_q <= ~zero_q;
						j_q <= j_q + 1'b1;
						st_q <= D_IRD;
					end else begin
						i_q <= j_q + 1'b1;
						st_q <= D_ORD;
					end
				end
				D_FIN: begin
					res.ok <= 1'b1;
					res.data <= (nb_q == 8'd0) ? 32'd0 : 32'(recx);
					res.bits <= (nb_q == 8'd0) ? 7'd0 : ((m > 8'd127) ? 7'd127 : m[6:0]);
					done <= 1'b1;
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/dali_manchester_transceiver_unit.sv
// A sample tick passes through S_EXEC, S_TXEX while sending, and S_FIN to the result register.
// A send builds its pulse list in memory through S_BA and S_BB for each bit; a delayed
// send then finishes, and an immediate send also passes S_START and S_TXGO.
// The tick that ends a frame adds the decoder walk, at worst quadratic in the run
// count. One item is in flight at a time.
// Reset clears all control state; the run and pulse memories are not cleared.
module dali_manchester_transceiver_unit #(
	parameter int MAX_RUNS = dmt_pkg::DEF_MAX_RUNS,
	parameter int MAX_TX_PULSES = dmt_pkg::DEF_MAX_TX_PULSES,
	parameter int FRAME_WIDTH = dmt_pkg::DEF_FRAME_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        rx_level,
	input  logic [31:0] message,
	input  logic [4:0]  frame_length,
	input  logic [15:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_level,
	output logic        send_accepted,
	output logic        send_done,
	output logic        frame_valid,
	output logic [31:0] frame_data,
	output logic [6:0]  frame_bits,
	output logic        line_error,
	output logic        receiving
);
	localparam int RAW = $clog2(MAX_RUNS);
	localparam int PAW = $clog2(MAX_TX_PULSES);
	localparam int PCW = $clog2(MAX_TX_PULSES + 1);
	localparam int RUN_W = dmt_pkg::RUN_W;

	typedef enum logic [1:0] {M_IDLE, M_RX, M_WAIT, M_TX} mode_t;
	typedef enum logic [3:0] {S_IDLE, S_EXEC, S_BA, S_BB, S_START, S_TXGO, S_TXEX,
		S_RXEND, S_DEC, S_FIN} state_t;

	// Bit k of the framed message: a start one, then data MSB first.
	function automatic logic bit_at(input logic [31:0] msg, input logic [4:0] len,
		input logic [5:0] k);
		logic [5:0] pos;
		pos = {1'b0, len} - k;
		return (k == 6'd0) ? 1'b1 : msg[pos[4:0]];
	endfunction

	// Ticks of one pulse, never below one.
	function automatic logic [15:0] pulse_ticks(input logic full, input logic [7:0] h);
		logic [8:0] t;
		t = full ? {h, 1'b0} : {1'b0, h};
		return (t == 9'd0) ? 16'd1 : {7'd0, t};
	endfunction

	logic rx_inv_q, tx_inv_q;
	logic [7:0] half_q, short_q;
	logic [6:0] hyst_q;

	state_t st_q;
	mode_t mode_q;
	logic [1:0] cmd_q;
	logic lvl_q;
	logic [31:0] msg_q;
	logic [4:0] len_q;
	logic [15:0] dly_q;
	logic [5:0] bi_q;
	logic curlvl_q;
	logic [RUN_W-1:0] curlen_q;
	logic [RAW-1:0] idx_q;
	logic [PCW-1:0] ptotal_q, pidx_q;
	logic [15:0] cd_q;
	logic drive_q;
	logic acc_q, done_q, fv_q, lerr_q;
	logic [31:0] fdata_q;
	logic [6:0] fbits_q;
	logic ov_q, o_tx_q, o_acc_q, o_done_q, o_fv_q, o_lerr_q, o_rx_q;
	logic [31:0] o_fdata_q;
	logic [6:0] o_fbits_q;

	logic pmem [MAX_TX_PULSES];
	logic p_rdata_q;
	logic [PAW-1:0] p_raddr;
	logic pw_en, pw_data;
	logic bcur, bprev, bnext;

	logic rw_en;
	logic [RAW-1:0] rw_addr;
	logic [RUN_W-1:0] rw_data;
	logic dec_start, dec_done;
	dmt_pkg::dec_res_t dec_res;

	logic same, ovf, rx_fin;
	logic [RUN_W-1:0] newlen, th3;
	logic [RAW-1:0] newidx;
	logic [15:0] cd_dec;

	assign in_ready = (st_q == S_IDLE) && (!ov_q || out_ready);

	// Pulse list memory.
	always_ff @(posedge clk) begin
		if (pw_en) pmem[ptotal_q[PAW-1:0]] <= pw_data;
		p_rdata_q <= pmem[p_raddr];
	end

	assign p_raddr = (st_q == S_EXEC && mode_q == M_TX) ? pidx_q[PAW-1:0] : '0;

	// Pulse list expansion: a full pulse between unequal neighbors.
	always_comb begin
		bcur = bit_at(msg_q, len_q, bi_q);
		bprev = bit_at(msg_q, len_q, bi_q - 6'd1);
		bnext = bit_at(msg_q, len_q, bi_q + 6'd1);
		pw_en = 1'b0;
		pw_data = 1'b0;
		if (ptotal_q < PCW'(MAX_TX_PULSES)) begin
			if (st_q == S_BA) pw_en = (bi_q == 6'd0) || (bcur == bprev);
			if (st_q == S_BB) begin
				pw_en = 1'b1;
				pw_data = !((bi_q == {1'b0, len_q}) || (bcur == bnext));
			end
		end
	end

	// Receive run tracking for one tick.
	always_comb begin
		same = (lvl_q == curlvl_q);
		ovf = !same && (({1'b0, idx_q} + 1'b1) >= (RAW+1)'(MAX_RUNS));
		newlen = same ? ((curlen_q == dmt_pkg::RUN_SAT) ? curlen_q : curlen_q + 1'b1)
			: RUN_W'(1);
		newidx = same ? idx_q : idx_q + 1'b1;
		th3 = RUN_W'(half_q) * RUN_W'(dmt_pkg::STOP_HALVES);
		rx_fin = (newlen >= th3) && (lvl_q != rx_inv_q);
		cd_dec = (cd_q == 16'd0) ? 16'd0 : cd_q - 16'd1;
	end

	// A finished run is written when the level changes and when the frame ends.
	always_comb begin
		rw_en = 1'b0;
		rw_addr = idx_q;
		rw_data = curlen_q;
		if (st_q == S_EXEC && cmd_q == dmt_pkg::CMD_TICK && mode_q == M_RX && !same && !ovf)
			rw_en = 1'b1;
		if (st_q == S_RXEND) rw_en = 1'b1;
	end

	assign dec_start = (st_q == S_RXEND);

	dmt_decoder #(.MAX_RUNS(MAX_RUNS), .FRAME_WIDTH(FRAME_WIDTH)) u_dec (
		.clk(clk), .arst_n(arst_n),
		.wr_en(rw_en), .wr_addr(rw_addr), .wr_data(rw_data),
		.start(dec_start), .run_total({1'b0, idx_q} + 1'b1),
		.half_ticks(half_q), .hyst_ticks(hyst_q), .short_limit(short_q),
		.done(dec_done), .res(dec_res)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_inv_q <= 1'b0;
			tx_inv_q <= 1'b0;
			half_q <= 8'd8;
			hyst_q <= 7'd2;
			short_q <= 8'd30;
		end else if (cfg_we) begin
			case (cfg_index)
				dmt_pkg::CFG_RX_INV: rx_inv_q <= cfg_wdata[0];
				dmt_pkg::CFG_TX_INV: tx_inv_q <= cfg_wdata[0];
				dmt_pkg::CFG_HALF: half_q <= cfg_wdata;
				dmt_pkg::CFG_HYST: hyst_q <= cfg_wdata[6:0];
				dmt_pkg::CFG_SHORT: short_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Control sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			mode_q <= M_IDLE;
			cmd_q <= '0; lvl_q <= 1'b0; msg_q <= '0; len_q <= '0; dly_q <= '0;
			bi_q <= '0;
			curlvl_q <= 1'b0; curlen_q <= '0; idx_q <= '0;
			ptotal_q <= '0; pidx_q <= '0; cd_q <= '0; drive_q <= 1'b1;
			acc_q <= 1'b0; done_q <= 1'b0; fv_q <= 1'b0; lerr_q <= 1'b0;
			fdata_q <= '0; fbits_q <= '0;
			ov_q <= 1'b0; o_tx_q <= 1'b0; o_acc_q <= 1'b0; o_done_q <= 1'b0;
			o_fv_q <= 1'b0; o_lerr_q <= 1'b0; o_rx_q <= 1'b0;
			o_fdata_q <= '0; o_fbits_q <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd; lvl_q <= rx_level; msg_q <= message;
						len_q <= frame_length; dly_q <= delay_ticks;
						acc_q <= 1'b0; done_q <= 1'b0; fv_q <= 1'b0; lerr_q <= 1'b0;
						fdata_q <= '0; fbits_q <= '0;
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= S_FIN;
					if (cmd_q == dmt_pkg::CMD_TICK) begin
						unique case (mode_q)
							M_TX, M_WAIT: st_q <= S_TXEX;
							M_IDLE: begin
								if (lvl_q == rx_inv_q) begin
									mode_q <= M_RX;
									idx_q <= '0;
									curlen_q <= RUN_W'(1);
									curlvl_q <= rx_inv_q;
								end
							end
							M_RX: begin
								if (ovf) begin
									lerr_q <= 1'b1;
									mode_q <= M_IDLE;
								end else begin
									curlen_q <= newlen;
									curlvl_q <= lvl_q;
									idx_q <= newidx;
									if (rx_fin) begin
										mode_q <= M_IDLE;
										st_q <= S_RXEND;
									end
								end
							end
							default: ;
						endcase
					end else if (cmd_q == dmt_pkg::CMD_SEND_NOW ||
						cmd_q == dmt_pkg::CMD_SEND_DELAY) begin
						if (mode_q != M_RX) begin
							acc_q <= 1'b1;
							ptotal_q <= '0;
							bi_q <= '0;
							st_q <= S_BA;
						end
					end
				end
				S_BA: begin
					if (pw_en) ptotal_q <= ptotal_q + 1'b1;
					st_q <= S_BB;
				end
				S_BB: begin
					if (pw_en) ptotal_q <= ptotal_q + 1'b1;
					if (bi_q == {1'b0, len_q}) begin
						if (cmd_q == dmt_pkg::CMD_SEND_NOW) begin
							st_q <= S_START;
						end else begin
							mode_q <= M_WAIT;
							cd_q <= dly_q;
							st_q <= S_FIN;
						end
					end else begin
						bi_q <= bi_q + 6'd1;
						st_q <= S_BA;
					end
				end
				S_START: st_q <= S_TXGO;
				S_TXGO: begin
					mode_q <= M_TX;
					pidx_q <= PCW'(1);
					cd_q <= pulse_ticks(p_rdata_q, half_q);
					drive_q <= ~drive_q;
					st_q <= S_FIN;
				end
				S_TXEX: begin
					cd_q <= cd_dec;
					if (cd_dec == 16'd0) begin
						if (mode_q == M_WAIT) begin
							mode_q <= M_TX;
							pidx_q <= PCW'(1);
							cd_q <= pulse_ticks(p_rdata_q, half_q);
							drive_q <= ~drive_q;
						end else if (pidx_q >= ptotal_q) begin
							drive_q <= 1'b1;
							mode_q <= M_IDLE;
							done_q <= 1'b1;
						end else begin
							drive_q <= ~drive_q;
							cd_q <= pulse_ticks(p_rdata_q, half_q);
							pidx_q <= pidx_q + 1'b1;
						end
					end
					st_q <= S_FIN;
				end
				S_RXEND: st_q <= S_DEC;
				S_DEC: begin
					if (dec_done) begin
						fv_q <= dec_res.ok;
						lerr_q <= ~dec_res.ok;
						fdata_q <= dec_res.data;
						fbits_q <= dec_res.bits;
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					ov_q <= 1'b1;
					o_tx_q <= drive_q ^ tx_inv_q;
					o_acc_q <= acc_q;
					o_done_q <= done_q;
					o_fv_q <= fv_q;
					o_lerr_q <= lerr_q;
					o_fdata_q <= fdata_q;
					o_fbits_q <= fbits_q;
					o_rx_q <= (mode_q == M_RX);
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign tx_level = o_tx_q;
	assign send_accepted = o_acc_q;
	assign send_done = o_done_q;
	assign frame_valid = o_fv_q;
	assign frame_data = o_fdata_q;
	assign frame_bits = o_fbits_q;
	assign line_error = o_lerr_q;
	assign receiving = o_rx_q;
endmodule

FILE: rtl/dmt_checker.sv
// Port-level checker for the DALI transceiver and its bind.
`include "dali_manchester_transceiver_unit_defines.svh"

module dmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tx_level,
	input logic        send_accepted,
	input logic        send_done,
	input logic        frame_valid,
	input logic [31:0] frame_data,
	input logic [6:0]  frame_bits,
	input logic        line_error,
	input logic        receiving
);
	// A result that is not taken stays offered.
	`DMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tx_level))
	// A frame and a line error never come from the same item.
	`DMT_ASSERT_NOW(a_fv_lerr, out_valid, !(frame_valid && line_error))
	// Without a frame the frame fields read zero.
	`DMT_ASSERT_NOW(a_fv_zero, out_valid && !frame_valid, frame_data == 32'd0 && frame_bits == 7'd0)
	// Sending and receiving exclude each other.
	`DMT_ASSERT_NOW(a_tx_rx, out_valid && (send_accepted || send_done), !receiving)
endmodule

bind dali_manchester_transceiver_unit dmt_checker u_dmt_checker (.*);

FILE: sim/dali_manchester_transceiver_checker.sv
// Line-behavior predictor and result checker for the DALI transceiver testbench.
module dali_manchester_transceiver_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        rx_level,
	input  logic [31:0] message,
	input  logic [4:0]  frame_length,
	input  logic [15:0] delay_ticks,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        tx_level,
	input  logic        send_accepted,
	input  logic        send_done,
	input  logic        frame_valid,
	input  logic [31:0] frame_data,
	input  logic [6:0]  frame_bits,
	input  logic        line_error,
	input  logic        receiving,
	output int          mismatches,
	output int          outstanding
);

	localparam int RUN_SLOTS = dmt_pkg::DEF_MAX_RUNS;
	localparam int PULSE_SLOTS = dmt_pkg::DEF_MAX_TX_PULSES;

	typedef enum bit [1:0] {LINE_IDLE, LINE_RX, LINE_WAIT, LINE_TX} line_mode_t;

	typedef struct {
		bit        tx;
		bit        accepted;
		bit        done;
		bit        fvalid;
		bit [31:0] fdata;
		bit [6:0]  fbits;
		bit        lerr;
		bit        rcv;
	} line_result_t;

	line_result_t line_results_q[$];

	// Configuration copy.
	bit       rx_inv, tx_inv;
	int       half_ticks, hyst_ticks, stop_limit;

	// Line state copy.
	line_mode_t line_mode;
	bit         rx_now;
	int         run_len [RUN_SLOTS];
	int         runs_seen;
	bit         pulse_full [PULSE_SLOTS];
	int         pulse_total, pulse_next, countdown;
	bit         drive;

	assign outstanding = line_results_q.size();

	function automatic int pulse_length(int k);
		int t;
		t = half_ticks;
		if (k < PULSE_SLOTS && pulse_full[k])
			t = t * 2;
		return (t != 0) ? t : 1;
	endfunction

	function automatic void append_pulse(bit full);
		if (pulse_total < PULSE_SLOTS) begin
			pulse_full[pulse_total] = full;
			pulse_total++;
		end
	endfunction

	// Expand start bit plus data bits, MSB first, into half and full pulses.
	function automatic void expand_frame(bit [31:0] msg, int len);
		bit sym [33];
		int n;
		n = len + 1;
		for (int i = 0; i < n; i++)
			sym[i] = (i == 0) ? 1'b1 : msg[len - i];
		pulse_total = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || sym[i] == sym[i-1])
				append_pulse(1'b0);
			if (i == n - 1 || sym[i] == sym[i+1])
				append_pulse(1'b0);
			else
				append_pulse(1'b1);
		end
	endfunction

	function automatic void begin_transmit();
		line_mode = LINE_TX;
		pulse_next = 1;
		countdown = pulse_length(0);
		drive = ~drive;
	endfunction

	function automatic dmt_pkg::cls_t run_class(int v);
		if (v >= half_ticks - hyst_ticks && v <= half_ticks + hyst_ticks)
			return dmt_pkg::CLS_HALF;
		if (v >= 2 * half_ticks - hyst_ticks && v <= 2 * half_ticks + hyst_ticks)
			return dmt_pkg::CLS_FULL;
		if (v >= 3 * half_ticks - hyst_ticks || v <= stop_limit)
			return dmt_pkg::CLS_STOP;
		return dmt_pkg::CLS_ERR;
	endfunction

	// Walk the stored runs and rebuild the frame; returns 0 on too few runs.
	function automatic bit decode_runs(output bit [31:0] data, output bit [6:0] nbits);
		dmt_pkg::cls_t cls [RUN_SLOTS];
		int       i, j, nb;
		bit [63:0] rec;
		bit       zero;
		nb = 0;
		rec = '0;
		zero = 1'b0;
		data = '0;
		nbits = '0;
		for (i = 0; i < runs_seen; i++)
			cls[i] = run_class(run_len[i]);
		if (runs_seen <= dmt_pkg::MIN_RUNS)
			return 1'b0;
		i = 0;
		while (i < runs_seen) begin
			if (cls[i] == dmt_pkg::CLS_STOP)
				break;
			for (j = i + 1; j < runs_seen; j++) begin
				rec = {rec[62:0], ~zero};
				nb++;
				if (cls[j] == dmt_pkg::CLS_FULL) begin
					zero = ~zero;
				end else begin
					i = j;
					break;
				end
			end
			i++;
		end
		rec = rec & 64'hFFFF_FFFF;
		if (nb == 0)
			return 1'b1;
		if (nb - 1 < 32)
			rec[nb-1] = ~rec[nb-1];
		data = rec[31:0];
		nbits = (nb - 1 > 127) ? 7'd127 : 7'(nb - 1);
		return 1'b1;
	endfunction

	// Advance the line state by one input item and return the expected result.
	function automatic line_result_t predict_line(bit [1:0] c, bit lvl, bit [31:0] msg,
		bit [4:0] flen, bit [15:0] dly);
		line_result_t r;
		bit start_lvl, ok;
		int idx;
		r = '{default: 0};
		start_lvl = rx_inv;
		if (c == dmt_pkg::CMD_SEND_NOW || c == dmt_pkg::CMD_SEND_DELAY) begin
			if (line_mode != LINE_RX) begin
				r.accepted = 1'b1;
				expand_frame(msg, int'(flen));
				if (c == dmt_pkg::CMD_SEND_NOW) begin
					begin_transmit();
				end else begin
					line_mode = LINE_WAIT;
					countdown = int'(dly);
				end
			end
		end else if (c == dmt_pkg::CMD_TICK) begin
			case (line_mode)
				LINE_TX: begin
					if (countdown > 0)
						countdown--;
					if (countdown == 0) begin
						if (pulse_next >= pulse_total) begin
							drive = 1'b1;
							line_mode = LINE_IDLE;
							r.done = 1'b1;
						end else begin
							drive = ~drive;
							countdown = pulse_length(pulse_next);
							pulse_next++;
						end
					end
				end
				LINE_WAIT: begin
					if (countdown > 0)
						countdown--;
					if (countdown == 0)
						begin_transmit();
				end
				LINE_IDLE: begin
					if (lvl == start_lvl) begin
						line_mode = LINE_RX;
						runs_seen = 0;
						run_len[0] = 1;
						rx_now = start_lvl;
					end
				end
				default: begin
					idx = runs_seen;
					ok = 1'b1;
					if (idx >= RUN_SLOTS) begin
						ok = 1'b0;
					end else if (lvl == rx_now) begin
						if (run_len[idx] < 1023)
							run_len[idx]++;
					end else if (idx + 1 >= RUN_SLOTS) begin
						ok = 1'b0;
					end else begin
						rx_now = lvl;
						idx++;
						runs_seen = idx;
						run_len[idx] = 1;
					end
					if (!ok) begin
						r.lerr = 1'b1;
						line_mode = LINE_IDLE;
					end else if (run_len[idx] >= 3 * half_ticks && lvl != start_lvl) begin
						runs_seen = idx + 1;
						line_mode = LINE_IDLE;
						if (decode_runs(r.fdata, r.fbits))
							r.fvalid = 1'b1;
						else
							r.lerr = 1'b1;
					end
				end
			endcase
		end
		if (!r.fvalid) begin
			r.fdata = '0;
			r.fbits = '0;
		end
		r.tx = drive ^ tx_inv;
		r.rcv = (line_mode == LINE_RX);
		return r;
	endfunction

	function automatic void check_field(string name, bit [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Track configuration, predict on input transfers, compare on output transfers.
	always @(posedge clk or negedge arst_n) begin
		line_result_t e;
		if (!arst_n) begin
			rx_inv = 1'b0;
			tx_inv = 1'b0;
			half_ticks = 8;
			hyst_ticks = 2;
			stop_limit = 30;
			line_mode = LINE_IDLE;
			rx_now = 1'b0;
			runs_seen = 0;
			pulse_total = 0;
			pulse_next = 0;
			countdown = 0;
			drive = 1'b1;
			mismatches = 0;
			line_results_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dmt_pkg::CFG_RX_INV: rx_inv = cfg_wdata[0];
					dmt_pkg::CFG_TX_INV: tx_inv = cfg_wdata[0];
					dmt_pkg::CFG_HALF:   half_ticks = int'(cfg_wdata);
					dmt_pkg::CFG_HYST:   hyst_ticks = int'(cfg_wdata[6:0]);
					dmt_pkg::CFG_SHORT:  stop_limit = int'(cfg_wdata);
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				line_results_q.push_back(predict_line(cmd, rx_level, message,
					frame_length, delay_ticks));
			if (out_valid && out_ready) begin
				if (line_results_q.size() == 0) begin
					$error("result transfer with no expected result pending");
					mismatches++;
				end else begin
					e = line_results_q.pop_front();
					check_field("tx_level", e.tx, tx_level);
					check_field("send_accepted", e.accepted, send_accepted);
					check_field("send_done", e.done, send_done);
					check_field("frame_valid", e.fvalid, frame_valid);
					check_field("frame_data", e.fdata, frame_data);
					check_field("frame_bits", e.fbits, frame_bits);
					check_field("line_error", e.lerr, line_error);
					check_field("receiving", e.rcv, receiving);
				end
			end
		end
	end

endmodule

FILE: sim/tb_dali_manchester_transceiver_unit.sv
// Stimulus and verdict for the DALI transceiver: line frames, sends, noise and stalls.
module tb_dali_manchester_transceiver_unit;

	localparam int QUIET_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic        rx_level;
	logic [31:0] message;
	logic [4:0]  frame_length;
	logic [15:0] delay_ticks;
	logic        out_valid;
	logic        out_ready;
	logic        tx_level;
	logic        send_accepted;
	logic        send_done;
	logic        frame_valid;
	logic [31:0] frame_data;
	logic [6:0]  frame_bits;
	logic        line_error;
	logic        receiving;

	int mismatches, outstanding;
	int items_sent, results_taken, quiet_cycles, ready_cycles;
	bit gap_free;
	bit cur_rx_inv;
	int cur_half, cur_hyst;

	dali_manchester_transceiver_unit dut (.*);

	dali_manchester_transceiver_checker checker_i (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: random stalls, one long hold-off, and a stall-free stretch.
	initial begin
		out_ready <= 1'b0;
		ready_cycles = 0;
		forever begin
			@(posedge clk);
			ready_cycles++;
			if (ready_cycles >= 1200 && ready_cycles < 1500)
				out_ready <= 1'b0;
			else if (ready_cycles >= 2500 && ready_cycles < 4000)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 35);
		end
	end

	// Count result transfers and watch for a stuck run.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			results_taken++;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one item and hold it until the transfer happens.
	task automatic push_item(bit [1:0] c, bit lvl, bit [31:0] msg, bit [4:0] flen,
		bit [15:0] dly);
		if (!gap_free) begin
			while ($urandom_range(0, 99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_level <= lvl;
		message <= msg;
		frame_length <= flen;
		delay_ticks <= dly;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic tick(bit lvl);
		push_item(dmt_pkg::CMD_TICK, lvl, $urandom, 5'($urandom_range(1, 31)),
			16'($urandom));
	endtask

	task automatic hold_level(bit lvl, int n);
		for (int k = 0; k < n; k++)
			tick(lvl);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_taken < items_sent);
	endtask

	// Write all five registers once the line has gone quiet.
	task automatic set_config(bit rxi, bit txi, int half, int hy, int lim);
		bit [7:0] vals [5];
		drain();
		vals = '{8'(rxi), 8'(txi), 8'(half), 8'(hy), 8'(lim)};
		for (int k = 0; k < 5; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(k);
			cfg_wdata <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_rx_inv = rxi;
		cur_half = half;
		cur_hyst = hy;
	endtask

	// Drive a bi-phase frame onto the receive line, with timing jitter and
	// an occasional badly sized half-bit.
	task automatic rx_frame(int nbits, bit [31:0] data);
		bit idle_lvl, start_lvl, b, broken;
		int jit, len;
		idle_lvl = ~cur_rx_inv;
		start_lvl = cur_rx_inv;
		jit = cur_hyst / 2;
		if (jit > (cur_half - 1) / 3)
			jit = (cur_half - 1) / 3;
		broken = ($urandom_range(0, 5) == 0);
		hold_level(idle_lvl, 2);
		for (int i = 0; i <= nbits; i++) begin
			b = (i == 0) ? 1'b1 : data[nbits - i];
			for (int h = 0; h < 2; h++) begin
				len = cur_half + $urandom_range(0, 2 * jit) - jit;
				if (broken && $urandom_range(0, 7) == 0)
					len = $urandom_range(1, 3 * cur_half);
				hold_level((b ^ (h == 1)) ? start_lvl : idle_lvl, len);
			end
		end
		hold_level(idle_lvl, 3 * cur_half + 1);
	endtask

	// Send a frame, now or delayed, sometimes replaced partway, and let it finish.
	task automatic tx_frame();
		int len, dly;
		bit [1:0] c;
		len = $urandom_range(1, 31);
		dly = $urandom_range(0, 20);
		c = $urandom_range(0, 1) ? dmt_pkg::CMD_SEND_NOW : dmt_pkg::CMD_SEND_DELAY;
		push_item(c, $urandom, $urandom, 5'(len), 16'(dly));
		if ($urandom_range(0, 3) == 0) begin
			hold_level(~cur_rx_inv, $urandom_range(1, 4 * cur_half));
			len = $urandom_range(1, 31);
			dly = 0;
			push_item(dmt_pkg::CMD_SEND_NOW, $urandom, $urandom, 5'(len), 16'($urandom));
		end
		hold_level(~cur_rx_inv, 2 * (len + 1) * cur_half + dly + 3);
	endtask

	// Bring the line back to idle after arbitrary traffic.
	task automatic recover();
		hold_level(~cur_rx_inv, 3 * cur_half + 2);
		push_item(dmt_pkg::CMD_SEND_NOW, 1'b0, $urandom, 5'd1, 16'($urandom));
		hold_level(~cur_rx_inv, 4 * cur_half + 4);
	endtask

	task automatic noise(int n);
		bit [1:0] c;
		for (int k = 0; k < n; k++) begin
			c = 2'($urandom_range(0, 3));
			push_item(c, $urandom, $urandom, 5'($urandom_range(1, 31)),
				($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
		end
	endtask

	// Toggle every tick until the run store overflows.
	task automatic overflow_runs();
		for (int k = 0; k < 140; k++)
			tick(cur_rx_inv ^ k[0]);
	endtask

	task automatic random_phase(int budget);
		int stop_at, pick;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			gap_free = (items_sent >= 500 && items_sent < 700);
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				rx_frame($urandom_range(0, 31), $urandom);
			end else if (pick < 80) begin
				tx_frame();
			end else if (pick < 95) begin
				noise($urandom_range(5, 25));
				recover();
			end else begin
				overflow_runs();
				recover();
			end
		end
		gap_free = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= dmt_pkg::CFG_RX_INV;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		cmd <= dmt_pkg::CMD_TICK;
		rx_level <= 1'b1;
		message <= '0;
		frame_length <= 5'd1;
		delay_ticks <= '0;
		items_sent = 0;
		results_taken = 0;
		quiet_cycles = 0;
		gap_free = 1'b0;
		cur_rx_inv = 1'b0;
		cur_half = 8;
		cur_hyst = 2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused command, refused sends while receiving, send replacement,
		// delay extremes and field extremes.
		tick(1'b1);
		push_item(dmt_pkg::CMD_RESERVED, 1'b0, 32'hFFFF_FFFF, 5'd31, 16'hFFFF);
		tick(1'b0);
		push_item(dmt_pkg::CMD_SEND_NOW, 1'b0, 32'hFFFF_FFFF, 5'd31, 16'h0);
		push_item(dmt_pkg::CMD_SEND_DELAY, 1'b1, 32'h0, 5'd1, 16'h0);
		tick(1'b1);
		hold_level(1'b1, 28);
		push_item(dmt_pkg::CMD_SEND_NOW, 1'b1, 32'hFFFF_FFFF, 5'd31, 16'hFFFF);
		push_item(dmt_pkg::CMD_SEND_DELAY, 1'b0, 32'h0, 5'd1, 16'hFFFF);
		push_item(dmt_pkg::CMD_SEND_NOW, 1'b0, 32'h0, 5'd1, 16'h0);
		hold_level(1'b1, 40);

		set_config(1'b0, 1'b0, 8, 2, 30);
		random_phase(50);
		set_config(1'b1, 1'b1, 4, 1, 30);
		random_phase(70);
		set_config(1'b0, 1'b1, 2, 0, 0);
		random_phase(70);
		set_config(1'b1, 1'b0, 3, 127, 255);
		random_phase(70);
		set_config(1'b0, 1'b0, 5, 2, 10);
		random_phase(70);

		// Slowest timing: a short send, then noise on the line.
		set_config(1'b1, 1'b1, 255, 0, 255);
		push_item(dmt_pkg::CMD_SEND_NOW, 1'b0, $urandom, 5'd1, 16'h0);
		hold_level(1'b0, 20);
		noise(30);

		set_config(1'b0, 1'b0, 4, 1, 30);
		recover();
		random_phase(70);
		set_config(1'b1, 1'b0, 2, 1, 0);
		random_phase(70);

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
